// ===== rtl/core/dclm_pkg.sv =====
// Shared constants, codes and types for the dual-color LED matrix scan driver.
package dclm_pkg;

  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 32;
  localparam int SCAN_ROWS    = 16;

  localparam int XW   = 6;                  // pixel_x and shift_column width
  localparam int YW   = 5;                  // pixel_y width and framebuffer row index
  localparam int SR_W = 4;                  // scan row counter width
  localparam int CW   = 2;                  // pixel_color width
  localparam int ROW_BITS = 2 * PANEL_WIDTH; // one framebuffer row: green above red

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_REFRESH = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [CW-1:0] COLOR_RED_BIT   = 2'h1;
  localparam logic [CW-1:0] COLOR_GREEN_BIT = 2'h2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_REFRESH,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [CW-1:0]   color;
  } cmd_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/dclm_front.sv =====
// Front end: accepts input beats and turns the meaningful ones into commands.
module dclm_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [dclm_pkg::XW-1:0]   pixel_x,
  input  logic [dclm_pkg::YW-1:0]   pixel_y,
  input  logic [dclm_pkg::CW-1:0]   pixel_color,
  input  logic                      q_full,
  output logic                      q_push,
  output dclm_pkg::cmd_t            q_cmd
);

  logic keep;
  logic in_range;

  always_comb begin
    in_range = ({1'b0, pixel_x} < (dclm_pkg::XW + 1)'(dclm_pkg::PANEL_WIDTH)) &&
               ({1'b0, pixel_y} < (dclm_pkg::YW + 1)'(dclm_pkg::PANEL_HEIGHT));
    q_cmd.x     = pixel_x;
    q_cmd.y     = pixel_y;
    q_cmd.color = pixel_color;
    q_cmd.op    = dclm_pkg::OP_WRITE;
    keep        = 1'b0;
    case (action)
      dclm_pkg::ACT_WRITE: begin
        q_cmd.op = dclm_pkg::OP_WRITE;
        keep     = in_range;
      end
      dclm_pkg::ACT_REFRESH: begin
        q_cmd.op = dclm_pkg::OP_REFRESH;
        keep     = 1'b1;
      end
      dclm_pkg::ACT_CLEAR: begin
        q_cmd.op = dclm_pkg::OP_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Dropped beats are still accepted, so ready only follows queue space.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

// ===== rtl/core/dclm_cmd_queue.sv =====
// Short command queue between the front end and the back end.
module dclm_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dclm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dclm_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  localparam int PW = $clog2(dclm_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(dclm_pkg::QUEUE_DEPTH + 1);

  dclm_pkg::cmd_t slots [dclm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == NW'(dclm_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(dclm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(dclm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dclm_back.sv =====
// Back end: framebuffer memory, pixel writes, clears and the row shift sequencer.
module dclm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  dclm_pkg::cmd_t              q_head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        red_top_level,
  output logic                        red_bottom_level,
  output logic                        green_top_level,
  output logic                        green_bottom_level,
  output logic [dclm_pkg::XW-1:0]     shift_column,
  output logic [dclm_pkg::SR_W-1:0]   row_address,
  output logic                        latch_last
);

  localparam int W = dclm_pkg::PANEL_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SHIFT
  } state_t;

  state_t                          state;
  logic [dclm_pkg::ROW_BITS-1:0]   frame_mem [dclm_pkg::PANEL_HEIGHT];
  logic [dclm_pkg::PANEL_HEIGHT-1:0] row_valid;
  logic [dclm_pkg::ROW_BITS-1:0]   rd_a;
  logic [dclm_pkg::ROW_BITS-1:0]   rd_b;
  logic                            rd_a_ok;
  logic                            rd_b_ok;
  logic [dclm_pkg::SR_W-1:0]       scan_row;
  logic [dclm_pkg::XW-1:0]         col;
  logic [dclm_pkg::YW-1:0]         wr_row;
  logic [dclm_pkg::XW-1:0]         wr_col;
  logic [dclm_pkg::CW-1:0]         wr_color;

  logic                            take_cmd;
  logic                            load;
  logic                            last_col;
  logic [dclm_pkg::YW-1:0]         top_idx;
  logic [dclm_pkg::YW:0]           bot_sum;
  logic                            top_ok;
  logic                            bot_ok;
  logic [dclm_pkg::YW-1:0]         rd_addr_a;
  logic [dclm_pkg::YW-1:0]         rd_addr_b;
  logic [dclm_pkg::ROW_BITS-1:0]   wr_data;

  always_comb begin
    take_cmd  = (state == ST_IDLE) && !q_empty;
    q_pop     = take_cmd;
    load      = !out_valid || out_ready;
    last_col  = (col == dclm_pkg::XW'(W - 1));
    top_idx   = dclm_pkg::YW'(scan_row);
    bot_sum   = {1'b0, top_idx} + (dclm_pkg::YW + 1)'(dclm_pkg::SCAN_ROWS);
    top_ok    = ({1'b0, top_idx} < (dclm_pkg::YW + 1)'(dclm_pkg::PANEL_HEIGHT));
    bot_ok    = top_ok && (bot_sum < (dclm_pkg::YW + 1)'(dclm_pkg::PANEL_HEIGHT));
    rd_addr_a = (q_head.op == dclm_pkg::OP_WRITE) ? q_head.y : top_idx;
    rd_addr_b = bot_sum[dclm_pkg::YW-1:0];

    // A row that has not been written since the last clear reads as all dark.
    wr_data = rd_a_ok ? rd_a : '0;
    wr_data[{1'b0, wr_col}] = |(wr_color & dclm_pkg::COLOR_RED_BIT);
    wr_data[{1'b0, wr_col} + (dclm_pkg::XW + 1)'(W)] =
      |(wr_color & dclm_pkg::COLOR_GREEN_BIT);
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      rd_a <= frame_mem[rd_addr_a];
      rd_b <= frame_mem[rd_addr_b];
    end
    if (state == ST_WRITE) begin
      frame_mem[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      scan_row  <= '0;
      row_valid <= '0;
      col       <= '0;
    end else begin
      // While shifting, a taken beat is always replaced by the next one below.
      if (out_valid && out_ready && (state != ST_SHIFT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            rd_a_ok <= row_valid[rd_addr_a] && ((q_head.op == dclm_pkg::OP_WRITE) || top_ok);
            rd_b_ok <= row_valid[rd_addr_b] && bot_ok;
            case (q_head.op)
              dclm_pkg::OP_WRITE: begin
                wr_row   <= q_head.y;
                wr_col   <= q_head.x;
                wr_color <= q_head.color;
                state    <= ST_WRITE;
              end
              dclm_pkg::OP_REFRESH: begin
                col   <= '0;
                state <= ST_SHIFT;
              end
              dclm_pkg::OP_CLEAR: begin
                row_valid <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WRITE: begin
          row_valid[wr_row] <= 1'b1;
          state             <= ST_IDLE;
        end
        ST_SHIFT: begin
          if (load) begin
            out_valid          <= 1'b1;
            red_top_level      <= !(rd_a_ok && rd_a[{1'b0, col}]);
            green_top_level    <= !(rd_a_ok && rd_a[{1'b0, col} + (dclm_pkg::XW + 1)'(W)]);
            red_bottom_level   <= !(rd_b_ok && rd_b[{1'b0, col}]);
            green_bottom_level <= !(rd_b_ok && rd_b[{1'b0, col} + (dclm_pkg::XW + 1)'(W)]);
            shift_column       <= col;
            row_address        <= last_col ? scan_row : '0;
            latch_last         <= last_col;
            if (last_col) begin
              scan_row <= (scan_row == dclm_pkg::SR_W'(dclm_pkg::SCAN_ROWS - 1)) ?
                          '0 : scan_row + 1'b1;
              state    <= ST_IDLE;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dual_color_led_matrix_scan_driver.sv =====
// Top level of the dual-color LED matrix scan driver.
// Scan driver for a 64x32 red/green panel at 1/16 multiplexing. Input beats go
// into a two-entry command queue and are carried out one at a time. A refresh
// first registers the top and bottom framebuffer rows read from the row
// memory and then emits 64 result beats, one per column, one per cycle when
// the consumer keeps out_ready high; the last beat carries the row address
// and latch strobe. A pixel write is a read-modify-write of one 128-bit row
// through the single memory write port. A clear only drops the per-row valid
// flags. Beats with the unused action code or an out-of-range pixel are
// accepted and dropped.
module dual_color_led_matrix_scan_driver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [dclm_pkg::XW-1:0]     pixel_x,
  input  logic [dclm_pkg::YW-1:0]     pixel_y,
  input  logic [dclm_pkg::CW-1:0]     pixel_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        red_top_level,
  output logic                        red_bottom_level,
  output logic                        green_top_level,
  output logic                        green_bottom_level,
  output logic [dclm_pkg::XW-1:0]     shift_column,
  output logic [dclm_pkg::SR_W-1:0]   row_address,
  output logic                        latch_last
);

  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  dclm_pkg::cmd_t q_cmd;
  dclm_pkg::cmd_t q_head;

  dclm_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  dclm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  dclm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_head             (q_head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .red_top_level      (red_top_level),
    .red_bottom_level   (red_bottom_level),
    .green_top_level    (green_top_level),
    .green_bottom_level (green_bottom_level),
    .shift_column       (shift_column),
    .row_address        (row_address),
    .latch_last         (latch_last)
  );

  // The latch strobe only appears with the final column of a row.
  a_latch_on_last_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && latch_last |-> shift_column == dclm_pkg::XW'(dclm_pkg::PANEL_WIDTH - 1))
    else $error("latch strobe on a column other than the last");

  a_row_address_only_on_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !latch_last |-> row_address == '0)
    else $error("row address driven on a non-latch beat");

  // Once a row has started, every taken beat is followed at once by the next column.
  a_columns_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !latch_last |=>
      out_valid && (shift_column == $past(shift_column) + 1'b1))
    else $error("row shift broke off or skipped a column");

endmodule
